### hdl/spe_pkg.sv
package spe_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_COEF   = 6;
  localparam int DEGREE_DEF = 5;

  localparam logic [WORD_W-1:0] Q_ONE = 32'h0001_0000;

  typedef enum logic [1:0] {
    OP_EVAL  = 2'd0,
    OP_DERIV = 2'd1,
    OP_INTEG = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    REG_COEF_0 = 3'd0,
    REG_COEF_1 = 3'd1,
    REG_COEF_2 = 3'd2,
    REG_COEF_3 = 3'd3,
    REG_COEF_4 = 3'd4,
    REG_COEF_5 = 3'd5,
    REG_SCALE  = 3'd6,
    REG_GAIN   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [WORD_W-1:0] point_a;
    logic [WORD_W-1:0] point_b;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              overflow;
  } out_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] val;
    logic              ovf;
  } q_res_t;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] u;
    logic [WORD_W-1:0] acc;
    logic              ovf;
  } lane_t;

  typedef struct packed {
    logic [1:0] op;
    lane_t      a;
    lane_t      b;
  } stage_t;

  function automatic q_res_t sat32(input logic signed [63:0] v);
    q_res_t r;
    if (v > 64'sd2147483647) begin
      r.val = 32'h7fff_ffff;
      r.ovf = 1'b1;
    end else if (v < -64'sd2147483648) begin
      r.val = 32'h8000_0000;
      r.ovf = 1'b1;
    end else begin
      r.val = v[WORD_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // q16.16 product, round half up, saturated
  function automatic q_res_t qmul(input logic signed [WORD_W-1:0] p,
                                  input logic signed [WORD_W-1:0] q);
    logic signed [63:0] pw;
    logic signed [63:0] qw;
    logic signed [63:0] prod;
    pw   = p;
    qw   = q;
    prod = pw * qw + 64'sd32768;
    return sat32(prod >>> 16);
  endfunction

  function automatic q_res_t sat_add(input logic signed [WORD_W-1:0] a,
                                     input logic signed [WORD_W-1:0] b);
    logic signed [63:0] aw;
    logic signed [63:0] bw;
    aw = a;
    bw = b;
    return sat32(aw + bw);
  endfunction

  function automatic q_res_t sat_sub(input logic signed [WORD_W-1:0] a,
                                     input logic signed [WORD_W-1:0] b);
    logic signed [63:0] aw;
    logic signed [63:0] bw;
    aw = a;
    bw = b;
    return sat32(aw - bw);
  endfunction

endpackage

### hdl/spe_coef.sv
module spe_coef #(
  parameter int DEGREE = spe_pkg::DEGREE_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_index_i,
  input  logic [spe_pkg::WORD_W-1:0]           cfg_data_i,
  output logic [DEGREE:0][spe_pkg::WORD_W-1:0] val_term_o,
  output logic [DEGREE:0][spe_pkg::WORD_W-1:0] der_term_o,
  output logic [DEGREE:0][spe_pkg::WORD_W-1:0] int_term_o,
  output logic [spe_pkg::WORD_W-1:0]           scale_o,
  output logic [spe_pkg::WORD_W-1:0]           gain_o,
  output logic [spe_pkg::WORD_W-1:0]           gs_o,
  output logic                                 gs_ovf_o,
  output logic                                 der_ovf_o
);

  logic [spe_pkg::NUM_COEF-1:0][spe_pkg::WORD_W-1:0] coef_q;
  logic [spe_pkg::WORD_W-1:0] scale_q;
  logic [spe_pkg::WORD_W-1:0] gain_q;

  logic [DEGREE:0][spe_pkg::WORD_W-1:0] coef_at;
  logic [DEGREE:0][spe_pkg::WORD_W-1:0] der_d;
  logic [DEGREE:0][spe_pkg::WORD_W-1:0] der_q;
  logic [DEGREE:0][spe_pkg::WORD_W-1:0] int_d;
  logic [DEGREE:0][spe_pkg::WORD_W-1:0] int_q;
  logic [DEGREE:0]                      der_sat;
  logic                                 der_ovf_d;
  logic                                 der_ovf_q;
  spe_pkg::q_res_t                      gs_d;
  spe_pkg::q_res_t                      gs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q  <= '0;
      scale_q <= spe_pkg::Q_ONE;
      gain_q  <= spe_pkg::Q_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        spe_pkg::REG_SCALE: scale_q <= cfg_data_i;
        spe_pkg::REG_GAIN:  gain_q  <= cfg_data_i;
        default:            coef_q[cfg_index_i] <= cfg_data_i;
      endcase
    end
  end

  for (genvar i = 0; i <= DEGREE; i++) begin : g_term
    localparam int unsigned DIV   = i + 1;
    localparam int          SH    = spe_pkg::WORD_W + $clog2(DIV);
    localparam logic [66:0] MAGIC = ((67'd1 << SH) + 67'(DIV) - 67'd1) / 67'(DIV);

    logic signed [63:0]         aw;
    logic [spe_pkg::WORD_W-1:0] mag;
    logic [66:0]                prod;
    logic [spe_pkg::WORD_W-1:0] quo;
    spe_pkg::q_res_t            dr;

    if (i < spe_pkg::NUM_COEF) begin : g_reg
      assign coef_at[i] = coef_q[i];
    end else begin : g_zero
      assign coef_at[i] = '0;
    end

    // i * a_i, saturated
    always_comb begin
      aw         = $signed(coef_at[i]);
      dr         = spe_pkg::sat32(aw * 64'(i));
      der_d[i]   = dr.val;
      der_sat[i] = (i > 0) ? dr.ovf : 1'b0;
    end

    // a_i / (i + 1) toward zero, by reciprocal
    always_comb begin
      mag      = coef_at[i][spe_pkg::WORD_W-1] ? (~coef_at[i] + 32'd1) : coef_at[i];
      prod     = 67'(mag) * MAGIC;
      quo      = prod[SH +: spe_pkg::WORD_W];
      int_d[i] = coef_at[i][spe_pkg::WORD_W-1] ? (~quo + 32'd1) : quo;
    end
  end

  assign der_ovf_d = |der_sat;
  assign gs_d      = spe_pkg::qmul(gain_q, scale_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      der_q     <= '0;
      int_q     <= '0;
      der_ovf_q <= 1'b0;
      gs_q      <= '{val: spe_pkg::Q_ONE, ovf: 1'b0};
    end else begin
      der_q     <= der_d;
      int_q     <= int_d;
      der_ovf_q <= der_ovf_d;
      gs_q      <= gs_d;
    end
  end

  assign val_term_o = coef_at;
  assign der_term_o = der_q;
  assign int_term_o = int_q;
  assign scale_o    = scale_q;
  assign gain_o     = gain_q;
  assign gs_o       = gs_q.val;
  assign gs_ovf_o   = gs_q.ovf;
  assign der_ovf_o  = der_ovf_q;

endmodule

### hdl/spe_scale.sv
module spe_scale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  spe_pkg::in_word_t          word_i,
  input  logic [spe_pkg::WORD_W-1:0] scale_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output spe_pkg::stage_t            data_o
);

  logic            valid_q;
  spe_pkg::stage_t data_d;
  spe_pkg::stage_t data_q;
  spe_pkg::q_res_t ua;
  spe_pkg::q_res_t ub;

  assign ready_o = !valid_q || ready_i;

  // u = s * x for both bounds
  always_comb begin
    ua            = spe_pkg::qmul(scale_i, word_i.point_a);
    ub            = spe_pkg::qmul(scale_i, word_i.point_b);
    data_d.op     = word_i.operation;
    data_d.a.x    = word_i.point_a;
    data_d.a.u    = ua.val;
    data_d.a.acc  = '0;
    data_d.a.ovf  = ua.ovf;
    data_d.b.x    = word_i.point_b;
    data_d.b.u    = ub.val;
    data_d.b.acc  = '0;
    data_d.b.ovf  = ub.ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hdl/spe_cell.sv
module spe_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  spe_pkg::stage_t            data_i,
  input  logic [spe_pkg::WORD_W-1:0] val_term_i,
  input  logic [spe_pkg::WORD_W-1:0] der_term_i,
  input  logic [spe_pkg::WORD_W-1:0] int_term_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output spe_pkg::stage_t            data_o
);

  logic                       valid_q;
  logic [spe_pkg::WORD_W-1:0] term;
  spe_pkg::stage_t            data_d;
  spe_pkg::stage_t            data_q;
  spe_pkg::q_res_t            ma;
  spe_pkg::q_res_t            mb;
  spe_pkg::q_res_t            sa;
  spe_pkg::q_res_t            sb;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    case (data_i.op)
      spe_pkg::OP_EVAL:  term = val_term_i;
      spe_pkg::OP_DERIV: term = der_term_i;
      default:           term = int_term_i;
    endcase
  end

  // one horner step, acc = acc * u + term, per lane
  always_comb begin
    ma           = spe_pkg::qmul(data_i.a.acc, data_i.a.u);
    sa           = spe_pkg::sat_add(ma.val, term);
    mb           = spe_pkg::qmul(data_i.b.acc, data_i.b.u);
    sb           = spe_pkg::sat_add(mb.val, term);
    data_d       = data_i;
    data_d.a.acc = sa.val;
    data_d.a.ovf = data_i.a.ovf | ma.ovf | sa.ovf;
    data_d.b.acc = sb.val;
    data_d.b.ovf = data_i.b.ovf | mb.ovf | sb.ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hdl/spe_finish.sv
module spe_finish (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  spe_pkg::stage_t            data_i,
  input  logic [spe_pkg::WORD_W-1:0] gain_i,
  input  logic [spe_pkg::WORD_W-1:0] gs_i,
  input  logic                       gs_ovf_i,
  input  logic                       der_ovf_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output spe_pkg::out_word_t         out_word_o
);

  typedef struct packed {
    logic [1:0]                 op;
    logic [spe_pkg::WORD_W-1:0] val_a;
    logic [spe_pkg::WORD_W-1:0] val_b;
    logic                       ovf_a;
    logic                       ovf_b;
  } f1_t;

  typedef struct packed {
    logic [1:0]                 op;
    logic [spe_pkg::WORD_W-1:0] val;
    logic                       ovf;
  } f2_t;

  logic                       v1_q;
  logic                       v2_q;
  logic                       out_valid_q;
  logic                       rdy1;
  logic                       rdy2;
  logic                       rdy3;
  f1_t                        f1_d;
  f1_t                        f1_q;
  f2_t                        f2_d;
  f2_t                        f2_q;
  spe_pkg::out_word_t         out_d;
  spe_pkg::out_word_t         out_q;
  spe_pkg::q_res_t            ma;
  spe_pkg::q_res_t            mb;
  spe_pkg::q_res_t            diff;
  spe_pkg::q_res_t            mg;
  logic [spe_pkg::WORD_W-1:0] mul_op;

  assign rdy3    = !out_valid_q || !out_stall_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // antiderivative needs the extra x factor
  always_comb begin
    ma         = spe_pkg::qmul(data_i.a.x, data_i.a.acc);
    mb         = spe_pkg::qmul(data_i.b.x, data_i.b.acc);
    f1_d.op    = data_i.op;
    f1_d.val_b = mb.val;
    f1_d.ovf_b = data_i.b.ovf | mb.ovf;
    if (data_i.op == spe_pkg::OP_INTEG) begin
      f1_d.val_a = ma.val;
      f1_d.ovf_a = data_i.a.ovf | ma.ovf;
    end else begin
      f1_d.val_a = data_i.a.acc;
      f1_d.ovf_a = data_i.a.ovf;
    end
  end

  always_comb begin
    diff    = spe_pkg::sat_sub(f1_q.val_b, f1_q.val_a);
    f2_d.op = f1_q.op;
    case (f1_q.op)
      spe_pkg::OP_INTEG: begin
        f2_d.val = diff.val;
        f2_d.ovf = f1_q.ovf_a | f1_q.ovf_b | diff.ovf;
      end
      default: begin
        f2_d.val = f1_q.val_a;
        f2_d.ovf = f1_q.ovf_a;
      end
    endcase
  end

  // final gain, g*s for the derivative
  always_comb begin
    mul_op = (f2_q.op == spe_pkg::OP_DERIV) ? gs_i : gain_i;
    mg     = spe_pkg::qmul(mul_op, f2_q.val);
    case (f2_q.op) inside
      spe_pkg::OP_EVAL, spe_pkg::OP_INTEG: begin
        out_d.value    = mg.val;
        out_d.overflow = f2_q.ovf | mg.ovf;
      end
      spe_pkg::OP_DERIV: begin
        out_d.value    = mg.val;
        out_d.overflow = f2_q.ovf | gs_ovf_i | der_ovf_i | mg.ovf;
      end
      default: begin
        out_d.value    = '0;
        out_d.overflow = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        out_valid_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      f1_q <= f1_d;
    end
    if (rdy2 && v1_q) begin
      f2_q <= f2_d;
    end
    if (rdy3 && v2_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_unused_op_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3 && !(f2_q.op == spe_pkg::OP_EVAL || f2_q.op == spe_pkg::OP_DERIV ||
                       f2_q.op == spe_pkg::OP_INTEG))
    |=> (out_valid_q && out_q.value == '0 && !out_q.overflow))
    else $error("unused operation did not give a zero word");

endmodule

### hdl/scaled_polynomial_evaluator_top.sv
// scaled polynomial evaluator, signed q16.16
// input channel: in_valid_i / in_stall_o carry in_word_i (operation, point_a,
//   point_b); a word is taken at a clock edge with valid high and stall low
// output channel: out_valid_o / out_stall_i carry out_word_o (value, overflow)
// config port: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (coef_0..coef_5, freq_scale, gain); write only while no word is in flight,
//   a word taken on the next cycle already sees the new value
// latency: DEGREE + 3 cycles from input edge to output valid (8 at degree 5):
//   the scale stage loads at the input edge, then one horner cell per degree
//   and three finishing stages
// throughput: one word per cycle; each horner cell holds one word and hands it
//   on every cycle, the cell multiplier sets the clock
// reset: coefficients clear to zero, scale and gain to 1.0, pipeline empties
// output stall: the result word holds, the stages behind it keep filling, and
//   in_stall_o rises only when every stage holds a word (DEGREE + 4 words)
module scaled_polynomial_evaluator_top #(
  parameter int DEGREE = spe_pkg::DEGREE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  spe_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output spe_pkg::out_word_t         out_word_o,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_index_i,
  input  logic [spe_pkg::WORD_W-1:0] cfg_data_i
);

  logic [DEGREE:0][spe_pkg::WORD_W-1:0] val_term;
  logic [DEGREE:0][spe_pkg::WORD_W-1:0] der_term;
  logic [DEGREE:0][spe_pkg::WORD_W-1:0] int_term;
  logic [spe_pkg::WORD_W-1:0]           scale;
  logic [spe_pkg::WORD_W-1:0]           gain;
  logic [spe_pkg::WORD_W-1:0]           gs;
  logic                                 gs_ovf;
  logic                                 der_ovf;

  spe_pkg::stage_t            cell_data  [DEGREE+1];
  logic                       cell_valid [DEGREE+1];
  logic                       cell_ready [DEGREE+1];
  logic                       fin_ready;
  logic                       scale_ready;
  spe_pkg::stage_t            head;
  logic [spe_pkg::WORD_W-1:0] acc_init;

  spe_coef #(
    .DEGREE(DEGREE)
  ) u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .val_term_o (val_term),
    .der_term_o (der_term),
    .int_term_o (int_term),
    .scale_o    (scale),
    .gain_o     (gain),
    .gs_o       (gs),
    .gs_ovf_o   (gs_ovf),
    .der_ovf_o  (der_ovf)
  );

  spe_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .ready_o(scale_ready),
    .word_i (in_word_i),
    .scale_i(scale),
    .valid_o(cell_valid[0]),
    .ready_i(cell_ready[0]),
    .data_o (cell_data[0])
  );

  assign in_stall_o = !scale_ready;

  // derivative starts from zero so its D steps run over d_D..d_1
  always_comb begin
    case (cell_data[0].op)
      spe_pkg::OP_EVAL:  acc_init = val_term[DEGREE];
      spe_pkg::OP_DERIV: acc_init = '0;
      default:           acc_init = int_term[DEGREE];
    endcase
    head       = cell_data[0];
    head.a.acc = acc_init;
    head.b.acc = acc_init;
  end

  for (genvar j = 1; j <= DEGREE; j++) begin : g_cell
    spe_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (cell_valid[j-1]),
      .ready_o   (cell_ready[j-1]),
      .data_i    ((j == 1) ? head : cell_data[j-1]),
      .val_term_i(val_term[DEGREE-j]),
      .der_term_i(der_term[DEGREE-j+1]),
      .int_term_i(int_term[DEGREE-j]),
      .valid_o   (cell_valid[j]),
      .ready_i   (cell_ready[j]),
      .data_o    (cell_data[j])
    );
  end

  assign cell_ready[DEGREE] = fin_ready;

  spe_finish u_finish (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (cell_valid[DEGREE]),
    .ready_o    (fin_ready),
    .data_i     (cell_data[DEGREE]),
    .gain_i     (gain),
    .gs_i       (gs),
    .gs_ovf_i   (gs_ovf),
    .der_ovf_i  (der_ovf),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  a_empty_front_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cell_valid[0] |-> !in_stall_o)
    else $error("input stalled with an empty scale stage");

  a_taken_word_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> cell_valid[0])
    else $error("accepted word missing from scale stage");

  a_drain_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while the output drains");

endmodule

### verif/tb.sv
module tb;

  localparam int POLY_DEG = spe_pkg::DEGREE_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned SMALL_Q = 32'h0002_0000;
  localparam logic [31:0] Q_MAX_W = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN_W = 32'h8000_0000;

  typedef logic signed [63:0] wide_t;
  typedef enum int {SERIES_VALUE, SERIES_SLOPE, SERIES_AREA} series_e;

  localparam wide_t Q_HI = 64'sd2147483647;
  localparam wide_t Q_LO = -64'sd2147483648;

  logic clk_i;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  spe_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  spe_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [spe_pkg::WORD_W-1:0] cfg_data = '0;

  scaled_polynomial_evaluator_top #(.DEGREE(POLY_DEG)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  spe_pkg::in_word_t point_words[$];
  spe_pkg::out_word_t predicted_results[$];
  spe_pkg::out_word_t want;
  logic [31:0] cfg_vals [8];

  wide_t shadow_coef [spe_pkg::NUM_COEF];
  wide_t shadow_scale;
  wide_t shadow_gain;
  logic sat_hit;

  int issued_count = 0;
  int checked_count = 0;
  int fail_count = 0;
  int phase_count = 0;
  int saturated_count = 0;
  int op_tally [4];
  int send_gap = 0;
  int send_quiet = 0;
  int hold_left = 0;
  int hold_quiet = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic wide_t q_clamp(input wide_t v);
    if (v > Q_HI) begin
      sat_hit = 1'b1;
      return Q_HI;
    end
    if (v < Q_LO) begin
      sat_hit = 1'b1;
      return Q_LO;
    end
    return v;
  endfunction

  // round half up, then clamp
  function automatic wide_t q_mul(input wide_t p, input wide_t q);
    wide_t prod;
    prod = p * q + 64'sd32768;
    return q_clamp(prod >>> 16);
  endfunction

  function automatic wide_t series_term(input series_e kind, input int i);
    wide_t a;
    a = (i >= spe_pkg::NUM_COEF) ? wide_t'(0) : shadow_coef[i];
    case (kind)
      SERIES_SLOPE: return q_clamp(a * wide_t'(i));
      SERIES_AREA:  return a / wide_t'(i + 1);
      default:      return a;
    endcase
  endfunction

  function automatic wide_t horner_sum(input series_e kind, input int lowest, input wide_t u);
    wide_t acc;
    acc = series_term(kind, POLY_DEG);
    for (int k = POLY_DEG - 1; k >= lowest; k--) begin
      acc = q_clamp(q_mul(acc, u) + series_term(kind, k));
    end
    return acc;
  endfunction

  function automatic wide_t antideriv_at(input wide_t x);
    return q_mul(x, horner_sum(SERIES_AREA, 0, q_mul(shadow_scale, x)));
  endfunction

  function automatic spe_pkg::out_word_t poly_result(input spe_pkg::in_word_t w);
    spe_pkg::out_word_t r;
    wide_t xa;
    wide_t xb;
    wide_t res;
    sat_hit = 1'b0;
    xa = signed'(w.point_a);
    xb = signed'(w.point_b);
    res = 0;
    case (w.operation)
      spe_pkg::OP_EVAL:
        res = q_mul(shadow_gain, horner_sum(SERIES_VALUE, 0, q_mul(shadow_scale, xa)));
      spe_pkg::OP_DERIV:
        res = q_mul(q_mul(shadow_gain, shadow_scale),
                    horner_sum(SERIES_SLOPE, 1, q_mul(shadow_scale, xa)));
      spe_pkg::OP_INTEG:
        res = q_mul(shadow_gain, q_clamp(antideriv_at(xb) - antideriv_at(xa)));
      default:  res = 0;
    endcase
    r.value = res[31:0];
    r.overflow = sat_hit;
    return r;
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int draw_gap(ref int quiet_left);
    int unsigned r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_fixed(input int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2 * lim) - lim;
    if (r < 85) return $urandom;
    if (r < 90) return Q_MAX_W;
    if (r < 95) return Q_MIN_W;
    return '0;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted_results.push_back(poly_result(in_word));
        op_tally[in_word.operation]++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (point_words.size() != 0) begin
          in_valid <= 1'b1;
          in_word <= point_words.pop_front();
          send_gap <= draw_gap(send_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("result word with no prediction pending: value %h", out_word.value);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          if (out_word.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, out_word.value);
            fail_count++;
          end
          if (out_word.overflow !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, out_word.overflow);
            fail_count++;
          end
          if (want.overflow) saturated_count++;
          checked_count++;
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else begin
        out_stall <= 1'b0;
        hold_left <= draw_gap(hold_quiet);
      end
    end
  end

  task automatic add_word(input logic [1:0] op, input logic [31:0] a, input logic [31:0] b);
    spe_pkg::in_word_t w;
    w.operation = op;
    w.point_a = a;
    w.point_b = b;
    point_words.push_back(w);
    issued_count++;
  endtask

  task automatic drain();
    while (checked_count != issued_count) @(posedge clk_i);
  endtask

  task automatic apply_config();
    spe_pkg::cfg_reg_e idx;
    idx = idx.first();
    do begin
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= cfg_vals[idx];
      if (idx == spe_pkg::REG_SCALE) shadow_scale = signed'(cfg_vals[idx]);
      else if (idx == spe_pkg::REG_GAIN) shadow_gain = signed'(cfg_vals[idx]);
      else shadow_coef[idx] = signed'(cfg_vals[idx]);
      idx = idx.next();
    end while (idx != idx.first());
    @(posedge clk_i);
    cfg_we <= 1'b0;
    phase_count++;
  endtask

  initial begin
    for (int k = 0; k < spe_pkg::NUM_COEF; k++) shadow_coef[k] = 0;
    shadow_scale = signed'(spe_pkg::Q_ONE);
    shadow_gain = signed'(spe_pkg::Q_ONE);
    for (int k = 0; k < 4; k++) op_tally[k] = 0;
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // register values straight out of reset
    add_word(spe_pkg::OP_EVAL, spe_pkg::Q_ONE, '0);
    add_word(spe_pkg::OP_DERIV, spe_pkg::Q_ONE, '0);
    add_word(spe_pkg::OP_INTEG, -spe_pkg::Q_ONE, spe_pkg::Q_ONE);
    drain();

    cfg_vals = '{32'h0000_8000, -32'h0001_4000, 32'h0000_c000, 32'h0000_199a,
                 -32'h0000_0ccd, 32'h0000_051f, 32'h0001_8000, 32'h0002_0000};
    apply_config();
    add_word(spe_pkg::OP_EVAL, '0, '0);
    add_word(spe_pkg::OP_EVAL, spe_pkg::Q_ONE, '0);
    add_word(spe_pkg::OP_EVAL, -spe_pkg::Q_ONE, '0);
    add_word(spe_pkg::OP_EVAL, Q_MAX_W, '0);
    add_word(spe_pkg::OP_EVAL, Q_MIN_W, Q_MAX_W);
    add_word(spe_pkg::OP_DERIV, 32'h0000_8000, '0);
    add_word(spe_pkg::OP_DERIV, -32'h0002_0000, '0);
    add_word(spe_pkg::OP_DERIV, Q_MAX_W, Q_MIN_W);
    add_word(spe_pkg::OP_INTEG, '0, spe_pkg::Q_ONE);
    add_word(spe_pkg::OP_INTEG, spe_pkg::Q_ONE, -spe_pkg::Q_ONE);
    add_word(spe_pkg::OP_INTEG, 32'h0003_0000, 32'h0003_0000);
    add_word(spe_pkg::OP_INTEG, Q_MIN_W, Q_MAX_W);
    add_word(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    drain();

    // zero scale: integral collapses to g*a0*(b-a)
    cfg_vals[spe_pkg::REG_SCALE] = '0;
    cfg_vals[spe_pkg::REG_GAIN] = -spe_pkg::Q_ONE;
    apply_config();
    add_word(spe_pkg::OP_INTEG, '0, 32'h0002_0000);
    add_word(spe_pkg::OP_INTEG, -32'h0003_0000, 32'h0005_0000);
    add_word(spe_pkg::OP_EVAL, 32'h0007_0000, '0);
    add_word(spe_pkg::OP_DERIV, spe_pkg::Q_ONE, '0);
    drain();

    cfg_vals = '{Q_MAX_W, Q_MIN_W, Q_MAX_W, Q_MIN_W, Q_MAX_W, Q_MIN_W, Q_MAX_W, Q_MIN_W};
    apply_config();
    add_word(spe_pkg::OP_EVAL, spe_pkg::Q_ONE, '0);
    add_word(spe_pkg::OP_DERIV, -spe_pkg::Q_ONE, '0);
    add_word(spe_pkg::OP_INTEG, '0, spe_pkg::Q_ONE);
    add_word(spe_pkg::OP_EVAL, '0, '0);
    drain();

    for (int p = 0; p < 9; p++) begin
      for (int k = 0; k < 8; k++) cfg_vals[k] = pick_fixed(SMALL_Q);
      apply_config();
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 99) < 6) begin
          add_word(OP_UNUSED, $urandom, $urandom);
        end else begin
          add_word(spe_pkg::op_e'($urandom_range(spe_pkg::OP_EVAL, spe_pkg::OP_INTEG)),
                   pick_fixed(SMALL_Q), pick_fixed(SMALL_Q));
        end
      end
      drain();
    end

    repeat (POLY_DEG + 8) @(posedge clk_i);
    if (predicted_results.size() != 0) fail_count++;
    $display("checked %0d result words over %0d register settings, %0d saturated",
             checked_count, phase_count, saturated_count);
    $display("words by operation: %0d value, %0d slope, %0d integral, %0d unused code",
             op_tally[spe_pkg::OP_EVAL], op_tally[spe_pkg::OP_DERIV],
             op_tally[spe_pkg::OP_INTEG], op_tally[OP_UNUSED]);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout with %0d of %0d results checked", checked_count, issued_count);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### scaled_polynomial_evaluator_top.f
hdl/spe_pkg.sv
hdl/spe_coef.sv
hdl/spe_scale.sv
hdl/spe_cell.sv
hdl/spe_finish.sv
hdl/scaled_polynomial_evaluator_top.sv
verif/tb.sv
